// ----- rtl/dss_pkg.sv -----
`default_nettype none

package dss_pkg;

  localparam int unsigned MaxPattern = 16;
  localparam int unsigned MaxText    = 65536;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned LenW   = $clog2(MaxPattern + 1);
  localparam int unsigned IdxW   = $clog2(MaxPattern);
  localparam int unsigned CountW = $clog2(MaxText + 2);
  localparam int unsigned StartW = 16;
  localparam int unsigned CfgW   = 64;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned OutDataW = ((CountW + 7) / 8) * 8;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPatternLow    = 3'd0,
    CfgPatternHigh   = 3'd1,
    CfgPatternLength = 3'd2,
    CfgStartPosition = 3'd3,
    CfgIgnoreCase    = 3'd4
  } cfg_index_e;

  typedef logic [ByteW-1:0] byte_t;

  function automatic byte_t fold_byte(input byte_t b, input logic ignore_case);
    byte_t r;
    r = b;
    if (ignore_case && (b >= 8'h41) && (b <= 8'h5a)) begin
      r = b + 8'h20;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/dbcs_substring_search.sv -----
// The last text beat is registered in the input register and its result then in the result register.
// Throughput: one text beat per cycle while no last beat is held; a beat is taken while an earlier result waits.
// A last beat waits in the input register only while the result register is still full.
// The search window, the byte counter and the match state update once per beat.
// Reset (asynchronous, active low) clears the text state and the result register and
// loads the configuration registers with their defaults (start position one).
`default_nettype none

module dbcs_substring_search (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [dss_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire logic [dss_pkg::CfgW-1:0]        cfg_data_i,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // Fields from bit 0: text_byte.
  input  wire logic [dss_pkg::ByteW-1:0]       s_axis_tdata,
  // Field: last_byte.
  input  wire logic                            s_axis_tlast,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // Fields from bit 0: position, then zero fill.
  output logic [dss_pkg::OutDataW-1:0]         m_axis_tdata,
  // Field: found.
  output logic                                 m_axis_tuser
);
  import dss_pkg::*;

  logic [CfgW-1:0]   pat_low_q, pat_high_q;
  logic [LenW-1:0]   pat_len_q;
  logic [StartW-1:0] start_q;
  logic              icase_q;

  logic [LenW-1:0]   len_d, len_q;
  logic [CountW:0]   first_d, first_q;
  logic              fold_d, fold_q;
  byte_t             apat_d [MaxPattern];
  byte_t             apat_q [MaxPattern];
  logic [MaxPattern-1:0] amask_d, amask_q;

  logic              in_valid_q, in_last_q;
  byte_t             in_byte_q;

  byte_t             win_q [MaxPattern];
  byte_t             win_n [MaxPattern];
  logic [MaxPattern-1:0] marks_q, marks_n;
  logic [CountW-1:0] count_q, count_n;
  logic              trail_q, latched_q;
  logic [CountW-1:0] mpos_q;

  logic              out_valid_q, found_q;
  logic [CountW-1:0] pos_q;

  logic              advance, in_take, cmp_ok, hit, latched_n;
  logic [CountW:0]   start_pos, cand_pos;
  logic [CountW-1:0] mpos_n;
  logic [IdxW-1:0]   top_idx;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      pat_len_q  <= '0;
      start_q    <= StartW'(1);
      icase_q    <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgPatternLow:    pat_low_q  <= cfg_data_i;
        CfgPatternHigh:   pat_high_q <= cfg_data_i;
        CfgPatternLength: pat_len_q  <= cfg_data_i[LenW-1:0];
        CfgStartPosition: start_q    <= cfg_data_i[StartW-1:0];
        CfgIgnoreCase:    icase_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // The pattern is stored end-aligned to the window so that the compare needs no shifter.
  always_comb begin
    logic [2*CfgW-1:0] pat_all;
    logic [LenW-1:0]   sel;
    pat_all = {pat_high_q, pat_low_q};
    len_d   = (pat_len_q > LenW'(MaxPattern)) ? LenW'(MaxPattern) : pat_len_q;
    fold_d  = icase_q;
    first_d = (start_q <= StartW'(1)) ? (CountW+1)'(1) : (CountW+1)'(start_q);
    for (int j = 0; j < MaxPattern; j++) begin
      sel        = len_d - LenW'(1) - LenW'(j);
      amask_d[j] = LenW'(j) < len_d;
      apat_d[j]  = fold_byte(pat_all[ByteW*sel[IdxW-1:0] +: ByteW], icase_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      first_q <= (CountW+1)'(1);
      fold_q  <= 1'b0;
      amask_q <= '0;
    end else begin
      len_q   <= len_d;
      first_q <= first_d;
      fold_q  <= fold_d;
      amask_q <= amask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    apat_q <= apat_d;
  end

  assign advance       = in_valid_q && (!in_last_q || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      in_last_q  <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
      in_last_q  <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  always_comb begin
    win_n[0]   = in_byte_q;
    marks_n[0] = !trail_q;
    for (int j = 1; j < MaxPattern; j++) begin
      win_n[j]   = win_q[j-1];
      marks_n[j] = marks_q[j-1];
    end
    cmp_ok = 1'b1;
    for (int j = 0; j < MaxPattern; j++) begin
      if (amask_q[j] && (fold_byte(win_n[j], fold_q) != apat_q[j])) begin
        cmp_ok = 1'b0;
      end
    end
  end

  assign count_n   = (count_q <= CountW'(MaxText)) ? count_q + CountW'(1) : count_q;
  assign top_idx   = IdxW'(len_q - LenW'(1));
  assign start_pos = (CountW+1)'(count_n) + (CountW+1)'(1);
  assign cand_pos  = first_q + (CountW+1)'(len_q);
  assign hit       = !latched_q && (len_q != '0) && (count_n >= CountW'(len_q))
                     && (count_n <= CountW'(MaxText)) && (start_pos >= cand_pos)
                     && marks_n[top_idx] && cmp_ok;
  assign latched_n = latched_q || hit;
  assign mpos_n    = latched_q ? mpos_q : CountW'(count_n - CountW'(len_q) + CountW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marks_q   <= '0;
      count_q   <= '0;
      trail_q   <= 1'b0;
      latched_q <= 1'b0;
      mpos_q    <= '0;
      for (int j = 0; j < MaxPattern; j++) begin
        win_q[j] <= '0;
      end
    end else if (advance) begin
      if (in_last_q) begin
        marks_q   <= '0;
        count_q   <= '0;
        trail_q   <= 1'b0;
        latched_q <= 1'b0;
        mpos_q    <= '0;
        for (int j = 0; j < MaxPattern; j++) begin
          win_q[j] <= '0;
        end
      end else begin
        marks_q   <= marks_n;
        count_q   <= count_n;
        trail_q   <= !trail_q && in_byte_q[ByteW-1];
        latched_q <= latched_n;
        mpos_q    <= mpos_n;
        win_q     <= win_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      pos_q       <= '0;
    end else if (advance && in_last_q) begin
      out_valid_q <= 1'b1;
      if (len_q == '0) begin
        found_q <= 1'b1;
        pos_q   <= CountW'(1);
      end else begin
        found_q <= latched_n;
        pos_q   <= latched_n ? mpos_n : '0;
      end
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataW'(pos_q);
  assign m_axis_tuser  = found_q;

endmodule

`default_nettype wire

// ----- rtl/dss_checker.sv -----
`default_nettype none

module dss_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        m_axis_tvalid,
  input wire logic                        m_axis_tready,
  input wire logic [dss_pkg::OutDataW-1:0] m_axis_tdata,
  input wire logic                        m_axis_tuser
);
  import dss_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("Result beat dropped while stalled.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("Position is not zero on a miss.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[CountW-1:0] != '0)
    else $error("Position is zero on a hit.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[CountW-1] |-> m_axis_tdata[CountW-2:0] == '0)
    else $error("Position beyond the longest text.");

endmodule

bind dbcs_substring_search dss_checker u_dss_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
